// File: hdl/assert_macros.svh
// Assertion macros for the encoder datapath.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LZW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LZW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LZW_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZW_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: hdl/lzw_pkg.sv
// Shared types for the LZW encoder: controller commands and datapath status.
// No dependencies.
package lzw_pkg;

    typedef struct packed {
        logic accept;      // take input transaction, issue first table read
        logic probe_next;  // slot taken by another key, read the next one
        logic take_hit;    // prefix becomes the found code
        logic learn;       // emit prefix, store pair if room, byte is prefix
        logic emit_final;  // emit prefix with end mark, drop prefix
        logic clear_step;  // clear one table slot after reset
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic have_prefix;
        logic slot_used;
        logic key_match;
        logic out_free;
    } status_t;

endpackage

// File: hdl/lzw_byte_encoder_core.sv
// LZW byte encoder, hashed dictionary of 2^CODE_BITS slots with linear probing.
// A byte with no held prefix is taken in the idle state; one with a prefix, hit or miss,
// also passes the compare state, staying for each further probe, and a final byte then
// passes the end emit state. Emits wait on a full output register. A code is presented
// the cycle after the probe or emit step that made it. Rate is set by the single table read
// port: one probe per cycle. After reset the table is swept clear before input is taken.
module lzw_byte_encoder_core
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 final_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_BITS-1:0] code_out,
    output logic                 stream_end
);
    cmd_t    cmd;
    status_t status;

    lzw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_byte (final_byte),
        .in_stall   (in_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lzw_datapath #(.CODE_BITS(CODE_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_out   (code_out),
        .stream_end (stream_end)
    );
endmodule

// File: hdl/lzw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/lzw_ctrl.sv
// Controller of the LZW encoder: sequences clear pass, lookup, learn and emit.
// Depends on lzw_pkg.
module lzw_ctrl
    import lzw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    final_byte,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);
    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       final_reg, final_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        final_next = final_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (status.clear_done)
                    state_next = ST_IDLE;
                else
                    cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    final_next = final_byte;
                    if (status.have_prefix)
                        state_next = ST_CMP;
                    else if (final_byte)
                        state_next = ST_FIN;
                end
            end
            ST_CMP:
            begin
                if (status.slot_used && status.key_match)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = final_reg ? ST_FIN : ST_IDLE;
                end
                else if (status.slot_used)
                begin
                    cmd.probe_next = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.learn  = 1'b1;
                    state_next = final_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end
endmodule

// File: hdl/lzw_datapath.sv
// Datapath of the LZW encoder: prefix and code registers, hashed dictionary
// table with linear probing, output register. Depends on lzw_pkg, lzw_ram.
`include "assert_macros.svh"
module lzw_datapath
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [7:0]           data_byte,
    output status_t              status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_BITS-1:0] code_out,
    output logic                 stream_end
);
    localparam int KEY_W  = CODE_BITS + 8;
    localparam int WORD_W = 1 + KEY_W + CODE_BITS;
    localparam int DEPTH  = 1 << CODE_BITS;

    logic [CODE_BITS-1:0] prefix_reg;
    logic                 have_prefix_reg;
    logic [CODE_BITS:0]   next_code_reg;
    logic [7:0]           byte_reg;
    logic [CODE_BITS-1:0] idx_reg;
    logic [CODE_BITS:0]   clr_cnt_reg;
    logic                 out_valid_reg;
    logic [CODE_BITS-1:0] code_out_reg;
    logic                 stream_end_reg;

    logic [CODE_BITS-1:0] raddr, waddr, hash;
    logic [WORD_W-1:0]    rdata, wdata;
    logic                 we, full, out_free;
    logic [KEY_W-1:0]     key;

    assign hash     = prefix_reg ^ (CODE_BITS'(data_byte) << (CODE_BITS - 8));
    assign key      = {prefix_reg, byte_reg};
    assign full     = next_code_reg[CODE_BITS];
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cmd.accept)
            raddr = hash;
        else if (cmd.probe_next)
            raddr = idx_reg + 1'b1;
        else
            raddr = idx_reg;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {1'b1, key, next_code_reg[CODE_BITS-1:0]};
        if (cmd.clear_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg[CODE_BITS-1:0];
            wdata = '0;
        end
        else if (cmd.learn && !full)
        begin
            we = 1'b1;
        end
    end

    lzw_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.clear_done  = clr_cnt_reg[CODE_BITS];
    assign status.have_prefix = have_prefix_reg;
    assign status.slot_used   = rdata[WORD_W-1];
    assign status.key_match   = (rdata[WORD_W-2:CODE_BITS] == key);
    assign status.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign code_out   = code_out_reg;
    assign stream_end = stream_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg      <= '0;
            have_prefix_reg <= 1'b0;
            next_code_reg   <= (CODE_BITS+1)'(256);
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.accept && !have_prefix_reg)
            begin
                prefix_reg      <= CODE_BITS'(data_byte);
                have_prefix_reg <= 1'b1;
            end
            if (cmd.take_hit)
                prefix_reg <= rdata[CODE_BITS-1:0];
            if (cmd.learn)
            begin
                prefix_reg <= CODE_BITS'(byte_reg);
                if (!full)
                    next_code_reg <= next_code_reg + 1'b1;
            end
            if (cmd.emit_final)
            begin
                prefix_reg      <= '0;
                have_prefix_reg <= 1'b0;
            end
            if (cmd.learn || cmd.emit_final)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= raddr;
        if (cmd.accept)
            byte_reg <= data_byte;
        if (cmd.learn || cmd.emit_final)
        begin
            code_out_reg   <= prefix_reg;
            stream_end_reg <= cmd.emit_final;
        end
    end

    `LZW_NEVER(a_learn_on_used, clk, rst_n, cmd.learn && rdata[WORD_W-1], "learn into used slot")
    `LZW_ASSERT(a_code_limit, clk, rst_n, next_code_reg <= (CODE_BITS+1)'(DEPTH), "code overrun")
    `LZW_NEVER(a_accept_clearing, clk, rst_n, cmd.accept && !clr_cnt_reg[CODE_BITS], "early accept")
    `LZW_NEVER(a_emit_overwrite, clk, rst_n, (cmd.learn || cmd.emit_final) && !out_free, "result lost")
endmodule
